// File: rtl/size_class_slab_allocator_top_macros.svh
// Assertion macros for the slab allocator RTL.
// Takes clk and rst_n from the module that uses them.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_TOP_MACROS_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SCSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SCSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/scsa_pkg.sv
// Shared types and constants of the slab allocator.
// No dependencies.
`timescale 1ns / 1ps

package scsa_pkg;

  localparam int PAGE_BYTES   = 8192;
  localparam int GRAIN_SHIFT  = 3;      // 8-byte grain
  localparam int NUM_CLASSES  = 1024;
  localparam int POOL_PAGES   = 64;
  localparam int HEADER_BYTES = 40;
  localparam int CAPACITY     = PAGE_BYTES - HEADER_BYTES;

  localparam int PAGE_W  = 6;
  localparam int OFF_W   = 13;
  localparam int CLS_W   = 10;
  localparam int CNT_W   = 10;
  localparam int BUMP_W  = 20;
  localparam int PT_W    = 7;
  localparam int SLOT_W  = OFF_W - GRAIN_SHIFT;
  localparam int ADDR_W  = 19;
  localparam int REQ_W   = 16;
  localparam int BSIZE_W = 14;
  localparam int QUO_W   = 13;

  localparam logic       OP_ALLOC   = 1'b0;
  localparam logic       OP_FREE    = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_EXHAUST = 2'd2;

  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0] page;
  } class_head_t;

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] off;
  } link_t;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [CNT_W-1:0]  used;
    logic              rec_ok;
    logic [OFF_W-1:0]  rec_head;
    logic [BUMP_W-1:0] bump;
    logic              next_ok;
    logic [PAGE_W-1:0] next_page;
  } page_rec_t;

  // Block size in bytes of a class.
  function automatic logic [BSIZE_W-1:0] class_bytes(input logic [CLS_W-1:0] cls);
    logic [BSIZE_W-1:0] n;
    n = {{(BSIZE_W-CLS_W){1'b0}}, cls} + BSIZE_W'(1);
    return n << GRAIN_SHIFT;
  endfunction

endpackage

// File: rtl/scsa_div.sv
// Bit-serial restoring divider: page capacity / block size = blocks per page.
// Depends on scsa_pkg.
`timescale 1ns / 1ps

module scsa_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [scsa_pkg::BSIZE_W-1:0] divisor,
  output logic                        busy,
  output logic [scsa_pkg::CNT_W-1:0]  quotient
);

  logic [scsa_pkg::BSIZE_W-1:0] rem_r, rem_nxt;
  logic [scsa_pkg::QUO_W-1:0]   quo_r, quo_nxt;
  logic [3:0]                   cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic [scsa_pkg::BSIZE_W-1:0] dvs_r, dvs_nxt;
  logic [scsa_pkg::BSIZE_W-1:0] trial;

  // one quotient bit per cycle
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r[scsa_pkg::BSIZE_W-2:0], quo_r[scsa_pkg::QUO_W-1]};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = scsa_pkg::QUO_W'(scsa_pkg::CAPACITY);
      cnt_nxt  = 4'(scsa_pkg::QUO_W);
      busy_nxt = 1'b1;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= dvs_r) begin
        rem_nxt = trial - dvs_r;
        quo_nxt = {quo_r[scsa_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[scsa_pkg::QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r[scsa_pkg::CNT_W-1:0];

endmodule

// File: rtl/size_class_slab_allocator_top.sv
// Slab allocator top level: sequencer, class/page/link memories, output register.
// Depends on scsa_pkg, scsa_div and size_class_slab_allocator_top_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction: opcode 0
//   allocates in_request_bytes, opcode 1 frees in_free_address.
//   Output channel (out_valid/out_stall) returns one result per transaction:
//   block address, status, blocks used in the touched page, block size.
//   Each transaction runs through a sequencer around one shared bit-serial
//   divider (for blocks per page) and memories with registered reads and
//   separate read and write ports. One transaction is in flight at a time;
//   in_stall is high while it runs. After reset the class head table is
//   swept empty, with in_stall high.
//   A result waits in the output register while out_stall is high; the
//   next transaction may be accepted meanwhile and its result holds in the
//   sequencer until the output register frees.
`timescale 1ns / 1ps
`include "size_class_slab_allocator_top_macros.svh"

module size_class_slab_allocator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [scsa_pkg::REQ_W-1:0]  in_request_bytes,
  input  logic [scsa_pkg::ADDR_W-1:0] in_free_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [scsa_pkg::ADDR_W-1:0] out_block_address,
  output logic [1:0]                  out_status,
  output logic [scsa_pkg::CNT_W-1:0]  out_page_blocks_used,
  output logic [12:0]                 out_page_block_size
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_ADIV = 4'd3;
  localparam logic [3:0] S_APG  = 4'd4;
  localparam logic [3:0] S_AFIN = 4'd5;
  localparam logic [3:0] S_FPG  = 4'd6;
  localparam logic [3:0] S_FDIV = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  localparam int PW = scsa_pkg::PAGE_W;
  localparam int CW = scsa_pkg::CLS_W;

  logic [3:0]                   state_r, state_nxt;
  logic [CW-1:0]                clr_idx_r, clr_idx_nxt;
  logic                         op_r;
  logic [scsa_pkg::REQ_W-1:0]   req_r;
  logic [scsa_pkg::ADDR_W-1:0]  faddr_r;
  logic [CW-1:0]                cls_r, cls_nxt;
  logic [PW-1:0]                p_r, p_nxt;
  logic [scsa_pkg::BSIZE_W-1:0] bsize_r, bsize_nxt;
  scsa_pkg::page_rec_t          pw_r, pw_nxt;
  logic [scsa_pkg::PT_W-1:0]    pages_taken_r, pages_taken_nxt;

  // pending result
  logic [scsa_pkg::ADDR_W-1:0]  res_addr_r, res_addr_nxt;
  logic [1:0]                   res_st_r, res_st_nxt;
  logic [scsa_pkg::CNT_W-1:0]   res_used_r, res_used_nxt;
  logic [12:0]                  res_bs_r, res_bs_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [scsa_pkg::ADDR_W-1:0]  out_addr_r;
  logic [1:0]                   out_st_r;
  logic [scsa_pkg::CNT_W-1:0]   out_used_r;
  logic [12:0]                  out_bs_r;
  logic                         out_load;

  // memories
  scsa_pkg::class_head_t cm [scsa_pkg::NUM_CLASSES];
  scsa_pkg::class_head_t cm_rd_r, cm_wdata;
  logic [CW-1:0]         cm_raddr, cm_waddr;
  logic                  cm_we;

  scsa_pkg::page_rec_t   pm [scsa_pkg::POOL_PAGES];
  scsa_pkg::page_rec_t   pm_rd_r, pm_wdata;
  logic [PW-1:0]         pm_raddr;
  logic                  pm_we;

  scsa_pkg::link_t       lm [scsa_pkg::POOL_PAGES * (1 << scsa_pkg::SLOT_W)];
  scsa_pkg::link_t       lm_rd_r, lm_wdata;
  logic [PW+scsa_pkg::SLOT_W-1:0] lm_raddr, lm_waddr;
  logic                  lm_we;

  // divider
  logic                         div_start, div_busy;
  logic [scsa_pkg::BSIZE_W-1:0] div_divisor;
  logic [scsa_pkg::CNT_W-1:0]   bpp;

  scsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (bpp)
  );

  logic                          in_acc;
  logic [scsa_pkg::REQ_W-1:0]    req_m1;
  logic [CW-1:0]                 req_cls;
  logic [PW-1:0]                 fpage;
  logic [scsa_pkg::OFF_W-1:0]    foff;
  logic [scsa_pkg::BUMP_W-1:0]   a_off;
  logic [scsa_pkg::CNT_W-1:0]    a_used;
  logic [scsa_pkg::BUMP_W-1:0]   addr_sum;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign req_m1   = req_r - scsa_pkg::REQ_W'(1);
  assign req_cls  = req_m1[scsa_pkg::OFF_W-1:scsa_pkg::GRAIN_SHIFT];
  assign fpage    = faddr_r[scsa_pkg::ADDR_W-1:scsa_pkg::OFF_W];
  assign foff     = faddr_r[scsa_pkg::OFF_W-1:0];

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    clr_idx_nxt     = clr_idx_r;
    cls_nxt         = cls_r;
    p_nxt           = p_r;
    bsize_nxt       = bsize_r;
    pw_nxt          = pw_r;
    pages_taken_nxt = pages_taken_r;
    res_addr_nxt    = res_addr_r;
    res_st_nxt      = res_st_r;
    res_used_nxt    = res_used_r;
    res_bs_nxt      = res_bs_r;
    cm_raddr        = cls_r;
    cm_we           = 1'b0;
    cm_waddr        = cls_r;
    cm_wdata        = '0;
    pm_raddr        = p_r;
    pm_we           = 1'b0;
    pm_wdata        = pw_r;
    lm_raddr        = {p_r, pm_rd_r.rec_head[scsa_pkg::OFF_W-1:scsa_pkg::GRAIN_SHIFT]};
    lm_we           = 1'b0;
    lm_waddr        = {p_r, foff[scsa_pkg::OFF_W-1:scsa_pkg::GRAIN_SHIFT]};
    lm_wdata        = '0;
    div_start       = 1'b0;
    div_divisor     = bsize_r;
    a_off           = '0;
    a_used          = '0;
    addr_sum        = '0;

    unique case (state_r)
      S_CLR: begin
        cm_we       = 1'b1;
        cm_waddr    = clr_idx_r;
        cm_wdata    = '0;
        clr_idx_nxt = clr_idx_r + CW'(1);
        if (clr_idx_r == CW'(scsa_pkg::NUM_CLASSES - 1)) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_acc) state_nxt = S_DEC;
      end

      S_DEC: begin
        if (op_r == scsa_pkg::OP_ALLOC) begin
          // zero or oversize; class index always fits once size fits a page
          if (req_r == '0 || req_r > scsa_pkg::REQ_W'(scsa_pkg::CAPACITY)) begin
            res_addr_nxt = '0;
            res_st_nxt   = scsa_pkg::ST_RANGE;
            res_used_nxt = '0;
            res_bs_nxt   = '0;
            state_nxt    = S_EMIT;
          end else begin
            cls_nxt     = req_cls;
            bsize_nxt   = scsa_pkg::class_bytes(req_cls);
            div_divisor = scsa_pkg::class_bytes(req_cls);
            div_start   = 1'b1;
            state_nxt   = S_ADIV;
          end
        end else begin
          if (faddr_r == '0 || {1'b0, fpage} >= pages_taken_r) begin
            res_addr_nxt = '0;
            res_st_nxt   = scsa_pkg::ST_OK;
            res_used_nxt = '0;
            res_bs_nxt   = '0;
            state_nxt    = S_EMIT;
          end else begin
            p_nxt     = fpage;
            pm_raddr  = fpage;
            state_nxt = S_FPG;
          end
        end
      end

      // class head read settles while blocks per page is computed
      S_ADIV: begin
        pm_raddr = cm_rd_r.page;
        if (!div_busy) begin
          if (!cm_rd_r.ok) begin
            if (pages_taken_r >= scsa_pkg::PT_W'(scsa_pkg::POOL_PAGES)) begin
              res_addr_nxt = '0;
              res_st_nxt   = scsa_pkg::ST_EXHAUST;
              res_used_nxt = '0;
              res_bs_nxt   = '0;
            end else begin
              // fresh page
              pm_we              = 1'b1;
              pm_raddr           = pages_taken_r[PW-1:0];
              pm_wdata.cls       = cls_r;
              pm_wdata.used      = scsa_pkg::CNT_W'(1);
              pm_wdata.rec_ok    = 1'b0;
              pm_wdata.rec_head  = '0;
              pm_wdata.bump      = scsa_pkg::BUMP_W'(scsa_pkg::PAGE_BYTES)
                                 - scsa_pkg::BUMP_W'(bsize_r);
              pm_wdata.next_ok   = 1'b0;
              pm_wdata.next_page = '0;
              p_nxt              = pages_taken_r[PW-1:0];
              pages_taken_nxt    = pages_taken_r + scsa_pkg::PT_W'(1);
              if (bpp > scsa_pkg::CNT_W'(1)) begin
                cm_we         = 1'b1;
                cm_wdata.ok   = 1'b1;
                cm_wdata.page = pages_taken_r[PW-1:0];
              end
              addr_sum     = {pages_taken_r[PW-1:0], {scsa_pkg::OFF_W{1'b0}}}
                           + pm_wdata.bump;
              res_addr_nxt = addr_sum[scsa_pkg::ADDR_W-1:0];
              res_st_nxt   = scsa_pkg::ST_OK;
              res_used_nxt = scsa_pkg::CNT_W'(1);
              res_bs_nxt   = bsize_r[12:0];
            end
            state_nxt = S_EMIT;
          end else begin
            p_nxt     = cm_rd_r.page;
            state_nxt = S_APG;
          end
        end
      end

      // page record in hand; link read issued for the recycled head
      S_APG: begin
        pw_nxt    = pm_rd_r;
        state_nxt = S_AFIN;
      end

      S_AFIN: begin
        pm_wdata = pw_r;
        if (pw_r.rec_ok) begin
          a_off             = scsa_pkg::BUMP_W'(pw_r.rec_head);
          pm_wdata.rec_head = lm_rd_r.off;
          pm_wdata.rec_ok   = lm_rd_r.ok;
        end else begin
          a_off         = pw_r.bump - scsa_pkg::BUMP_W'(bsize_r);
          pm_wdata.bump = a_off;
        end
        a_used        = pw_r.used + scsa_pkg::CNT_W'(1);
        pm_wdata.used = a_used;
        // page full: drop it from the class list
        if (a_used >= bpp) begin
          cm_we           = 1'b1;
          cm_wdata.ok     = pw_r.next_ok;
          cm_wdata.page   = pw_r.next_page;
          pm_wdata.rec_ok = 1'b0;
        end
        pm_we        = 1'b1;
        addr_sum     = {p_r, {scsa_pkg::OFF_W{1'b0}}} + a_off;
        res_addr_nxt = addr_sum[scsa_pkg::ADDR_W-1:0];
        res_st_nxt   = scsa_pkg::ST_OK;
        res_used_nxt = a_used;
        res_bs_nxt   = bsize_r[12:0];
        state_nxt    = S_EMIT;
      end

      S_FPG: begin
        pw_nxt      = pm_rd_r;
        cls_nxt     = pm_rd_r.cls;
        bsize_nxt   = scsa_pkg::class_bytes(pm_rd_r.cls);
        div_divisor = scsa_pkg::class_bytes(pm_rd_r.cls);
        div_start   = 1'b1;
        state_nxt   = S_FDIV;
      end

      S_FDIV: begin
        if (!div_busy) begin
          res_addr_nxt = '0;
          res_st_nxt   = scsa_pkg::ST_OK;
          res_bs_nxt   = bsize_r[12:0];
          if (pw_r.used == '0) begin
            res_used_nxt = '0;
          end else begin
            pm_wdata = pw_r;
            // full page rejoins its class list at the head
            if (pw_r.used == bpp) begin
              pm_wdata.next_ok   = cm_rd_r.ok;
              pm_wdata.next_page = cm_rd_r.page;
              cm_we              = 1'b1;
              cm_wdata.ok        = 1'b1;
              cm_wdata.page      = p_r;
            end
            lm_we             = 1'b1;
            lm_wdata.ok       = pw_r.rec_ok;
            lm_wdata.off      = pw_r.rec_head;
            pm_wdata.rec_head = foff;
            pm_wdata.rec_ok   = 1'b1;
            pm_wdata.used     = pw_r.used - scsa_pkg::CNT_W'(1);
            pm_we             = 1'b1;
            res_used_nxt      = pm_wdata.used;
          end
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_load) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      clr_idx_r     <= '0;
      pages_taken_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_idx_r     <= clr_idx_nxt;
      pages_taken_r <= pages_taken_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    if (in_acc) begin
      op_r    <= in_opcode;
      req_r   <= in_request_bytes;
      faddr_r <= in_free_address;
    end
    cls_r      <= cls_nxt;
    p_r        <= p_nxt;
    bsize_r    <= bsize_nxt;
    pw_r       <= pw_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    res_used_r <= res_used_nxt;
    res_bs_r   <= res_bs_nxt;
    if (out_load) begin
      out_addr_r <= res_addr_r;
      out_st_r   <= res_st_r;
      out_used_r <= res_used_r;
      out_bs_r   <= res_bs_r;
    end
  end

  // class head table
  always_ff @(posedge clk) begin
    if (cm_we) cm[cm_waddr] <= cm_wdata;
    cm_rd_r <= cm[cm_raddr];
  end

  // page records; written at the page latched for this transaction
  always_ff @(posedge clk) begin
    if (pm_we) pm[p_nxt] <= pm_wdata;
    pm_rd_r <= pm[pm_raddr];
  end

  // recycled block links
  always_ff @(posedge clk) begin
    if (lm_we) lm[lm_waddr] <= lm_wdata;
    lm_rd_r <= lm[lm_raddr];
  end

  assign out_valid            = out_valid_r;
  assign out_block_address    = out_addr_r;
  assign out_status           = out_st_r;
  assign out_page_blocks_used = out_used_r;
  assign out_page_block_size  = out_bs_r;

  // checks
  `SCSA_ASSERT_IMP(a_fail_clean, out_valid && out_status != scsa_pkg::ST_OK,
                   out_block_address == '0 && out_page_blocks_used == '0,
                   "failed request carries a page result")
  `SCSA_ASSERT_IMP(a_pool_bound, 1'b1,
                   pages_taken_r <= scsa_pkg::PT_W'(scsa_pkg::POOL_PAGES),
                   "page pool count overrun")
  `SCSA_ASSERT_NXT(a_page_step, 1'b1,
                   pages_taken_r == $past(pages_taken_r)
                   || pages_taken_r == $past(pages_taken_r) + scsa_pkg::PT_W'(1),
                   "page pool count jumped")
  `SCSA_ASSERT_IMP(a_div_idle, state_r == S_IDLE || state_r == S_EMIT,
                   !div_busy, "divider running outside a transaction")

endmodule

// File: tb/sv/slab_result_checker.sv
// Result checker for the slab allocator: watches both channels, predicts
// every result from its own allocator state and compares. Depends on scsa_pkg.
`timescale 1ns / 1ps

module slab_result_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [scsa_pkg::REQ_W-1:0]  in_request_bytes,
  input  logic [scsa_pkg::ADDR_W-1:0] in_free_address,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [scsa_pkg::ADDR_W-1:0] out_block_address,
  input  logic [1:0]                  out_status,
  input  logic [scsa_pkg::CNT_W-1:0]  out_page_blocks_used,
  input  logic [12:0]                 out_page_block_size,
  output int                          fail_count,
  output int                          pending_count
);

  localparam int PAGE_BYTES = scsa_pkg::PAGE_BYTES;
  localparam int CAPACITY   = scsa_pkg::CAPACITY;
  localparam int NCLS       = scsa_pkg::NUM_CLASSES;
  localparam int NPAGES     = scsa_pkg::POOL_PAGES;
  localparam int SLOTS      = PAGE_BYTES / 8;

  typedef struct packed {
    logic [scsa_pkg::ADDR_W-1:0] addr;
    logic [1:0]                  status;
    logic [scsa_pkg::CNT_W-1:0]  used;
    logic [12:0]                 bsize;
  } slab_result_t;

  slab_result_t result_queue[$];

  // Shadow allocator state
  int  head_page [NCLS];
  bit  head_ok   [NCLS];
  int  pg_cls    [NPAGES];
  int  pg_used   [NPAGES];
  int  pg_rec    [NPAGES];
  bit  pg_rec_ok [NPAGES];
  int  pg_bump   [NPAGES];
  int  pg_next   [NPAGES];
  bit  pg_next_ok[NPAGES];
  int  link      [NPAGES*SLOTS];
  bit  link_ok   [NPAGES*SLOTS];
  int  pages_used_total;

  function automatic slab_result_t mk(int a, int s, int u, int b);
    slab_result_t r;
    r.addr   = scsa_pkg::ADDR_W'(a);
    r.status = 2'(s);
    r.used   = scsa_pkg::CNT_W'(u);
    r.bsize  = 13'(b);
    return r;
  endfunction

  function automatic slab_result_t predict_alloc(int req);
    int cls, bsize, bpp, p, off, slot;
    if (req == 0 || req > CAPACITY) return mk(0, scsa_pkg::ST_RANGE, 0, 0);
    cls = (req + 7) / 8 - 1;
    if (cls >= NCLS) return mk(0, scsa_pkg::ST_RANGE, 0, 0);
    bsize = (cls + 1) * 8;
    bpp = CAPACITY / bsize;
    if (!head_ok[cls]) begin
      if (pages_used_total >= NPAGES) return mk(0, scsa_pkg::ST_EXHAUST, 0, 0);
      p = pages_used_total++;
      pg_cls[p] = cls; pg_rec_ok[p] = 0; pg_rec[p] = 0;
      pg_next_ok[p] = 0; pg_next[p] = 0; pg_used[p] = 1;
      pg_bump[p] = PAGE_BYTES - bsize;
      off = pg_bump[p];
      if (bpp > 1) begin
        head_page[cls] = p; head_ok[cls] = 1;
      end
    end else begin
      p = head_page[cls] % NPAGES;
      if (pg_rec_ok[p]) begin
        off = pg_rec[p] % PAGE_BYTES;
        slot = p * SLOTS + off / 8;
        pg_rec[p] = link[slot]; pg_rec_ok[p] = link_ok[slot];
      end else begin
        pg_bump[p] = (pg_bump[p] - bsize) & 32'hFFFFF;
        off = pg_bump[p];
      end
      pg_used[p]++;
      if (pg_used[p] >= bpp) begin
        head_page[cls] = pg_next[p]; head_ok[cls] = pg_next_ok[p];
        pg_rec_ok[p] = 0;
      end
    end
    return mk((p * PAGE_BYTES + off) & 32'h7FFFF, scsa_pkg::ST_OK, pg_used[p], bsize);
  endfunction

  function automatic slab_result_t predict_free(int addr);
    int p, off, cls, bpp, slot;
    p = addr / PAGE_BYTES;
    off = addr % PAGE_BYTES;
    if (addr == 0 || p >= pages_used_total) return mk(0, scsa_pkg::ST_OK, 0, 0);
    cls = pg_cls[p];
    bpp = CAPACITY / ((cls + 1) * 8);
    if (pg_used[p] == 0) return mk(0, scsa_pkg::ST_OK, 0, (cls + 1) * 8);
    if (pg_used[p] == bpp) begin
      pg_next[p] = head_page[cls]; pg_next_ok[p] = head_ok[cls];
      head_page[cls] = p; head_ok[cls] = 1;
    end
    slot = p * SLOTS + off / 8;
    link[slot] = pg_rec[p]; link_ok[slot] = pg_rec_ok[p];
    pg_rec[p] = off; pg_rec_ok[p] = 1;
    pg_used[p]--;
    return mk(0, scsa_pkg::ST_OK, pg_used[p], (cls + 1) * 8);
  endfunction

  initial begin
    fail_count = 0;
    pages_used_total = 0;
    foreach (head_ok[i]) head_ok[i] = 0;
  end

  assign pending_count = result_queue.size();

  // Predict on each accepted input transaction, compare each output one
  always @(posedge clk) begin
    slab_result_t got, want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        result_queue.push_back(in_opcode == scsa_pkg::OP_ALLOC ?
          predict_alloc(int'(in_request_bytes)) : predict_free(int'(in_free_address)));
      if (out_valid && !out_stall) begin
        got = mk(int'(out_block_address), int'(out_status), int'(out_page_blocks_used),
                 int'(out_page_block_size));
        if (result_queue.size() == 0) begin
          $error("unexpected result transaction addr=%0d", got.addr);
          fail_count++;
        end else begin
          want = result_queue.pop_front();
          if (got.addr !== want.addr) begin
            $error("block_address expected %0d actual %0d", want.addr, got.addr);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            fail_count++;
          end
          if (got.used !== want.used) begin
            $error("page_blocks_used expected %0d actual %0d", want.used, got.used);
            fail_count++;
          end
          if (got.bsize !== want.bsize) begin
            $error("page_block_size expected %0d actual %0d", want.bsize, got.bsize);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the slab allocator: clock, reset, stimulus and verdict.
// Depends on scsa_pkg, size_class_slab_allocator_top and slab_result_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int CAPACITY       = scsa_pkg::CAPACITY;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic in_opcode = scsa_pkg::OP_ALLOC;
  logic [scsa_pkg::REQ_W-1:0]  in_request_bytes = '0;
  logic [scsa_pkg::ADDR_W-1:0] in_free_address = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [scsa_pkg::ADDR_W-1:0] out_block_address;
  logic [1:0]                  out_status;
  logic [scsa_pkg::CNT_W-1:0]  out_page_blocks_used;
  logic [12:0]                 out_page_block_size;
  int fail_count, pending_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 0;
  int idle_cycles = 0;

  // Addresses handed out so far, fed back as well-formed frees
  int live_addr[$];

  always #5 clk = ~clk;

  size_class_slab_allocator_top u_dut (.*);

  slab_result_checker u_chk (.*);

  // Capture allocated addresses for later frees
  always @(posedge clk)
    if (out_valid && !out_stall && out_status == scsa_pkg::ST_OK && out_block_address != 0)
      live_addr.push_back(int'(out_block_address));

  // Receiver: random stall, or a long counted hold-off
  always @(negedge clk) begin
    if (hold_recv) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on cycles with no accepted transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // One transaction, with a random leading gap; valid drops only in a gap
  task automatic send_txn(input logic op, input int req, input int addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_request_bytes <= scsa_pkg::REQ_W'(req);
    in_free_address <= scsa_pkg::ADDR_W'(addr);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Allocs of mostly small sizes, a few large, some out of range; frees of live or random addresses
  task automatic random_txn();
    int r, idx, a;
    r = $urandom_range(99);
    if (r < 50) begin
      if ($urandom_range(9) < 7) send_txn(scsa_pkg::OP_ALLOC, $urandom_range(256, 1), $urandom);
      else if ($urandom_range(9) < 8)
        send_txn(scsa_pkg::OP_ALLOC, $urandom_range(CAPACITY), $urandom);
      else send_txn(scsa_pkg::OP_ALLOC, $urandom, $urandom);
    end else if (r < 56) begin
      send_txn(scsa_pkg::OP_ALLOC, $urandom_range(64, 1), $urandom);
    end else if (r < 90 && live_addr.size() > 0) begin
      idx = $urandom_range(live_addr.size() - 1);
      a = live_addr[idx];
      live_addr.delete(idx);
      send_txn(scsa_pkg::OP_FREE, $urandom, a);
    end else begin
      send_txn(scsa_pkg::OP_FREE, $urandom, $urandom_range(scsa_pkg::ADDR_W'('1)));
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1;

    // Directed: extremes and special cases
    send_txn(scsa_pkg::OP_ALLOC, 0, 0);                  // zero size
    send_txn(scsa_pkg::OP_ALLOC, CAPACITY + 1, 0);       // just oversize
    send_txn(scsa_pkg::OP_ALLOC, 16'hFFFF, 19'h7FFFF);   // max request
    send_txn(scsa_pkg::OP_FREE, 0, 0);                   // free of address zero
    send_txn(scsa_pkg::OP_FREE, 16'hFFFF, 19'h7FFFF);    // page not yet taken
    send_txn(scsa_pkg::OP_ALLOC, 1, 0);                  // smallest class
    send_txn(scsa_pkg::OP_ALLOC, 8, 0);
    send_txn(scsa_pkg::OP_ALLOC, CAPACITY, 0);           // one block per page
    send_txn(scsa_pkg::OP_ALLOC, 4000, 0);               // two blocks per page
    send_txn(scsa_pkg::OP_ALLOC, 4000, 0);               // page fills
    drain();
    send_txn(scsa_pkg::OP_FREE, 0, live_addr.pop_back()); // full page back to class
    send_txn(scsa_pkg::OP_ALLOC, 4000, 0);               // reuse from recycled list
    send_txn(scsa_pkg::OP_FREE, 0, 8192 * 1 + 100);      // free in the page of the one-block class
    send_txn(scsa_pkg::OP_FREE, 0, 8192 * 0 + 13);       // unaligned address
    send_txn(scsa_pkg::OP_ALLOC, 2, 0);
    send_txn(scsa_pkg::OP_FREE, 0, 8192 * 0 + 8000);     // never-allocated address
    drain();

    // Random phases: receiver-heavy idle, sender-heavy idle, no idle
    send_idle_pct = 36; recv_idle_pct = 88;
    repeat (400) random_txn();
    drain();
    send_idle_pct = 88; recv_idle_pct = 36;
    repeat (400) random_txn();
    drain();                                   // sender waits for all results
    send_idle_pct = 0; recv_idle_pct = 0;
    fork
      begin
        hold_recv = 1;
        repeat (300) @(negedge clk);
        hold_recv = 0;
      end
      repeat (10) random_txn();
    join
    repeat (390) random_txn();
    // Exhaust the pool with many distinct classes
    for (int i = 0; i < 70; i++) send_txn(scsa_pkg::OP_ALLOC, 8 * (200 + i), 0);
    drain();

    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
